// ===== rtl/core/htw_pkg.sv =====
// Shared definitions for the hierarchical timer wheel.
// Holds default sizes, handle encoding, command and result codes, and sequencer states.
// Used by the core and the port checker.
package htw_pkg;

	localparam int SLOT_BITS_DEF  = 8;
	localparam int LEVELS_DEF     = 4;
	localparam int NUM_TIMERS_DEF = 32;

	// A handle in a list link or slot head; all ones marks an empty link.
	typedef logic [5:0] hid_t;
	localparam hid_t NIL = 6'd63;

	typedef enum logic [1:0] {
		CMD_SCHED  = 2'd0,
		CMD_CANCEL = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_SCHED_ACK  = 2'd0,
		KIND_CANCEL_ACK = 2'd1,
		KIND_EXPIRY     = 2'd2,
		KIND_TICK_DONE  = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCH_CMP,
		ST_SCH_SET,
		ST_U1,
		ST_U2,
		ST_U3,
		ST_U4,
		ST_ARM,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_D0,
		ST_D1,
		ST_D2,
		ST_C_RD,
		ST_C_PL,
		ST_X_RD,
		ST_X_ARM,
		ST_SCAN,
		ST_ACK
	} state_t;

endpackage

// ===== rtl/core/htw_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
module htw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/hierarchical_timer_wheel.sv =====
// Hierarchical timer wheel: schedule, cancel and tick over a pool of timer handles.
// Schedule and cancel each end with one ack. A tick empties the due slot, cascades entries
// down from the higher levels, reports each expiry, re-arms the repeating ones and then
// scans the level-0 bitmap before its tick done result.
// Items are taken one at a time whenever busy is low; results cannot be stalled.
// After reset the slot RAM is swept empty while busy is high.
module hierarchical_timer_wheel
	import htw_pkg::*;
#(
	parameter int SLOT_BITS  = SLOT_BITS_DEF,
	parameter int LEVELS     = LEVELS_DEF,
	parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [4:0]  timer_id,
	input  logic [31:0] delay_ticks,
	input  logic        repeat_req,
	output logic        valid,
	output logic [1:0]  kind,
	output logic [4:0]  fired_id,
	output logic        ok,
	output logic [8:0]  remain_ticks,
	output logic        last
);

	localparam int WSIZE    = 1 << SLOT_BITS;
	localparam int NSLOTS   = LEVELS * WSIZE;
	localparam int LV_W     = $clog2(LEVELS);
	localparam int SA_W     = LV_W + SLOT_BITS;
	localparam int IDW      = $clog2(NUM_TIMERS);
	localparam int CNT_W    = $clog2(NUM_TIMERS + 1);
	localparam int EW       = 76 + SA_W;
	localparam int BM_W     = (WSIZE < 32) ? WSIZE : 32;
	localparam int BM_WORDS = WSIZE / BM_W;
	localparam int K_W      = $clog2(BM_WORDS + 1);
	localparam hid_t NUM_H  = hid_t'(NUM_TIMERS);

	typedef logic [SA_W-1:0]      saddr_t;
	typedef logic [SLOT_BITS-1:0] sidx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [LV_W-1:0]      lv_t;
	typedef logic [IDW-1:0]       eaddr_t;
	typedef logic [EW-1:0]        ent_t;
	typedef logic [K_W-1:0]       scan_t;

	// A link names a live entry only when it is inside the pool.
	function automatic logic hv(hid_t x);
		return x < NUM_H;
	endfunction

	state_t state_q, state_d, ret_q;
	cmd_t   cmd_q;

	logic [31:0]           tick_q;
	logic [NUM_TIMERS-1:0] pend_q, repf_q;
	logic [WSIZE-1:0]      bm_q;
	saddr_t                clr_q;

	hid_t        id_q;
	logic [31:0] dly_q;
	logic        rep_q, ok_q;

	hid_t   u_prev_q, u_next_q;
	saddr_t u_slot_q;

	hid_t        pid_q, pt_q;
	logic [31:0] ed_q, pd_q, pf_q;
	saddr_t      ps_q;
	logic        plv0_q;

	saddr_t ds_q;
	lv_t    clv_q;
	logic   xmode_q;
	hid_t   list_q [NUM_TIMERS];
	cnt_t   n_q, i_q;
	scan_t  k_q;

	logic       valid_q, ok_out_q, last_q;
	kind_t      kind_q;
	logic [4:0] fid_q;
	logic [8:0] rem_q;

	// Memory ports.
	logic   ent_we, slot_we;
	eaddr_t ent_wa, ent_ra;
	saddr_t slot_wa, slot_ra;
	ent_t   ent_wd, ent_rd;
	logic [11:0] slot_wd, slot_rd;

	// Result strobe for the next cycle.
	logic        e_v, e_ok, e_last;
	kind_t       e_kind;
	logic [4:0]  e_id;
	logic [8:0]  e_rem;

	htw_ram #(.WIDTH(EW), .DEPTH(NUM_TIMERS)) u_ent_ram (
		.clk  (clk),
		.we   (ent_we),
		.waddr(ent_wa),
		.wdata(ent_wd),
		.raddr(ent_ra),
		.rdata(ent_rd)
	);

	htw_ram #(.WIDTH(12), .DEPTH(NSLOTS)) u_slot_ram (
		.clk  (clk),
		.we   (slot_we),
		.waddr(slot_wa),
		.wdata(slot_wd),
		.raddr(slot_ra),
		.rdata(slot_rd)
	);

	// Fields of the entry and slot words read last cycle.
	hid_t        e_next, e_prev, s_head, s_tail, in_id, cur_e;
	saddr_t      e_place;
	logic [31:0] e_fire, e_delay;

	assign e_next  = ent_rd[5:0];
	assign e_prev  = ent_rd[11:6];
	assign e_place = ent_rd[12 +: SA_W];
	assign e_fire  = ent_rd[12 + SA_W +: 32];
	assign e_delay = ent_rd[44 + SA_W +: 32];
	assign s_head  = slot_rd[11:6];
	assign s_tail  = slot_rd[5:0];
	assign in_id   = hid_t'(timer_id);
	assign cur_e   = list_q[i_q[IDW-1:0]];

	// Level and slot for the entry being placed.
	lv_t    p_lv;
	saddr_t p_slot;

	always_comb begin
		p_lv = lv_t'(LEVELS - 1);
		for (int l = LEVELS - 2; l >= 0; l--) begin
			if ({32'b0, pd_q} < (64'd1 << ((l + 1) * SLOT_BITS))) begin
				p_lv = lv_t'(l);
			end
		end
		p_slot = '0;
		for (int l = 0; l < LEVELS; l++) begin
			if (p_lv == lv_t'(l)) begin
				p_slot = {lv_t'(l), pf_q[l * SLOT_BITS +: SLOT_BITS]};
			end
		end
	end

	// Arm delay and cascade distance.
	logic [31:0] a_d, t_next, c_df;
	sidx_t       c_idx, n_idx;
	logic        c_end;

	assign a_d    = (ed_q == 32'd0 || ed_q[31]) ? 32'd1 : ed_q;
	assign t_next = tick_q + 32'd1;
	assign c_df   = e_fire - tick_q;
	assign c_idx  = sidx_t'(tick_q >> (int'(clv_q) * SLOT_BITS));
	assign n_idx  = sidx_t'(tick_q >> ((int'(clv_q) + 1) * SLOT_BITS));
	assign c_end  = (c_idx != sidx_t'(0)) || (clv_q == lv_t'(LEVELS - 1));

	// Unlink head and tail update.
	hid_t u_nh, u_nt;

	assign u_nh = hv(u_prev_q) ? s_head : u_next_q;
	assign u_nt = hv(u_next_q) ? s_tail : u_prev_q;

	// Level-0 bitmap scan, one word a cycle, starting at the slot of the next tick.
	sidx_t            sc_start, sc_pos, sc_base, sc_off, sc_hit, sc_dist;
	logic [BM_W-1:0]  sc_word, sc_mask;
	logic             sc_found, sc_done;

	always_comb begin
		sc_start = tick_q[SLOT_BITS-1:0] + sidx_t'(1);
		sc_pos   = sc_start + sidx_t'(int'(k_q) * BM_W);
		sc_base  = sc_pos & ~sidx_t'(BM_W - 1);
		sc_off   = sc_start & sidx_t'(BM_W - 1);
		sc_word  = bm_q[sc_base +: BM_W];
		for (int j = 0; j < BM_W; j++) begin
			if (k_q == scan_t'(0)) begin
				sc_mask[j] = sc_word[j] && (sidx_t'(j) >= sc_off);
			end else if (k_q == scan_t'(BM_WORDS)) begin
				sc_mask[j] = sc_word[j] && (sidx_t'(j) < sc_off);
			end else begin
				sc_mask[j] = sc_word[j];
			end
		end
		sc_found = |sc_mask;
		sc_hit   = sc_base;
		for (int j = BM_W - 1; j >= 0; j--) begin
			if (sc_mask[j]) begin
				sc_hit = sc_base | sidx_t'(j);
			end
		end
		sc_dist = sc_hit - sc_start;
		sc_done = sc_found || (k_q == scan_t'(BM_WORDS));
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == saddr_t'(NSLOTS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					unique case (cmd_t'(command))
						CMD_SCHED: begin
							if (!hv(in_id)) state_d = ST_ACK;
							else if (pend_q[in_id[IDW-1:0]]) state_d = ST_SCH_CMP;
							else state_d = ST_SCH_SET;
						end
						CMD_CANCEL: begin
							if (hv(in_id) && pend_q[in_id[IDW-1:0]]) state_d = ST_U1;
							else state_d = ST_ACK;
						end
						CMD_TICK: state_d = ST_D0;
						CMD_NOP:  state_d = ST_IDLE;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_SCH_CMP: state_d = (e_delay == dly_q) ? ST_ACK : ST_U1;
			ST_U1:      state_d = ST_U2;
			ST_U2:      state_d = ST_U3;
			ST_U3:      state_d = ST_U4;
			ST_U4:      state_d = (cmd_q == CMD_CANCEL) ? ST_ACK : ST_SCH_SET;
			ST_SCH_SET: state_d = ST_ARM;
			ST_ARM:     state_d = ST_P0;
			ST_P0:      state_d = ST_P1;
			ST_P1:      state_d = hv(s_tail) ? ST_P2 : ret_q;
			ST_P2:      state_d = ret_q;
			ST_D0:      state_d = ST_D1;
			ST_D1: begin
				if (hv(s_head)) state_d = ST_D2;
				else state_d = xmode_q ? ST_X_RD : ST_C_RD;
			end
			ST_D2: begin
				if (!(hv(e_next) && n_q < cnt_t'(NUM_TIMERS))) begin
					state_d = xmode_q ? ST_X_RD : ST_C_RD;
				end
			end
			ST_C_RD:  state_d = (i_q == n_q) ? ST_D0 : ST_C_PL;
			ST_C_PL:  state_d = ST_P0;
			ST_X_RD: begin
				if (i_q == n_q) state_d = ST_SCAN;
				else if (repf_q[cur_e[IDW-1:0]]) state_d = ST_X_ARM;
			end
			ST_X_ARM: state_d = ST_ARM;
			ST_SCAN:  state_d = sc_done ? ST_IDLE : ST_SCAN;
			ST_ACK:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Memory controls and result strobe.
	always_comb begin
		ent_we  = 1'b0;
		ent_wa  = '0;
		ent_wd  = ent_rd;
		ent_ra  = '0;
		slot_we = 1'b0;
		slot_wa = '0;
		slot_wd = {NIL, NIL};
		slot_ra = '0;
		e_v     = 1'b0;
		e_kind  = KIND_SCHED_ACK;
		e_id    = '0;
		e_ok    = 1'b0;
		e_rem   = '0;
		e_last  = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				slot_we = 1'b1;
				slot_wa = clr_q;
			end
			ST_IDLE:    ent_ra = in_id[IDW-1:0];
			ST_SCH_CMP: ent_ra = id_q[IDW-1:0];
			ST_U1:      slot_ra = e_place;
			ST_U2: begin
				slot_we = 1'b1;
				slot_wa = u_slot_q;
				slot_wd = {u_nh, u_nt};
				ent_ra  = u_prev_q[IDW-1:0];
			end
			ST_U3: begin
				ent_we = hv(u_prev_q);
				ent_wa = u_prev_q[IDW-1:0];
				ent_wd = {ent_rd[EW-1:6], u_next_q};
				ent_ra = u_next_q[IDW-1:0];
			end
			ST_U4: begin
				ent_we = hv(u_next_q);
				ent_wa = u_next_q[IDW-1:0];
				ent_wd = {ent_rd[EW-1:12], u_prev_q, ent_rd[5:0]};
			end
			ST_P0: slot_ra = p_slot;
			ST_P1: begin
				ent_we  = 1'b1;
				ent_wa  = pid_q[IDW-1:0];
				ent_wd  = {ed_q, pf_q, ps_q, s_tail, NIL};
				slot_we = 1'b1;
				slot_wa = ps_q;
				slot_wd = {hv(s_tail) ? s_head : pid_q, pid_q};
				ent_ra  = s_tail[IDW-1:0];
			end
			ST_P2: begin
				ent_we = 1'b1;
				ent_wa = pt_q[IDW-1:0];
				ent_wd = {ent_rd[EW-1:6], pid_q};
			end
			ST_D0: slot_ra = ds_q;
			ST_D1: begin
				slot_we = 1'b1;
				slot_wa = ds_q;
				ent_ra  = s_head[IDW-1:0];
			end
			ST_D2:   ent_ra = e_next[IDW-1:0];
			ST_C_RD: ent_ra = cur_e[IDW-1:0];
			ST_X_RD: begin
				ent_ra = cur_e[IDW-1:0];
				if (i_q != n_q) begin
					e_v    = 1'b1;
					e_kind = KIND_EXPIRY;
					e_id   = cur_e[4:0];
				end
			end
			ST_SCAN: begin
				if (sc_done) begin
					e_v    = 1'b1;
					e_kind = KIND_TICK_DONE;
					e_rem  = sc_found ? 9'(sc_dist) : 9'(WSIZE);
					e_last = 1'b1;
				end
			end
			ST_ACK: begin
				e_v    = 1'b1;
				e_kind = (cmd_q == CMD_CANCEL) ? KIND_CANCEL_ACK : KIND_SCHED_ACK;
				e_id   = id_q[4:0];
				e_ok   = ok_q;
				e_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			ret_q   <= ST_ACK;
			clr_q   <= '0;
			tick_q  <= '0;
			pend_q  <= '0;
			repf_q  <= '0;
			bm_q    <= '0;
			clv_q   <= '0;
			xmode_q <= 1'b0;
			n_q     <= '0;
			i_q     <= '0;
			k_q     <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= e_v;
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + saddr_t'(1);
				ST_IDLE: begin
					ret_q <= ST_ACK;
					if (start && cmd_t'(command) == CMD_TICK) begin
						tick_q <= t_next;
						if (t_next[SLOT_BITS-1:0] == sidx_t'(0)) begin
							clv_q   <= lv_t'(1);
							xmode_q <= 1'b0;
						end else begin
							clv_q   <= '0;
							xmode_q <= 1'b1;
						end
					end
				end
				ST_U2: begin
					pend_q[id_q[IDW-1:0]] <= 1'b0;
					if (u_slot_q[SA_W-1:SLOT_BITS] == lv_t'(0) && u_nh == NIL) begin
						bm_q[u_slot_q[SLOT_BITS-1:0]] <= 1'b0;
					end
				end
				ST_SCH_SET: repf_q[id_q[IDW-1:0]] <= rep_q;
				ST_ARM:     pend_q[pid_q[IDW-1:0]] <= 1'b1;
				ST_P1: begin
					if (plv0_q) bm_q[ps_q[SLOT_BITS-1:0]] <= 1'b1;
				end
				ST_D1: begin
					i_q <= '0;
					n_q <= hv(s_head) ? cnt_t'(1) : cnt_t'(0);
					if (ds_q[SA_W-1:SLOT_BITS] == lv_t'(0)) begin
						bm_q[ds_q[SLOT_BITS-1:0]] <= 1'b0;
					end
				end
				ST_D2: begin
					if (hv(e_next) && n_q < cnt_t'(NUM_TIMERS)) n_q <= n_q + cnt_t'(1);
				end
				ST_C_RD: begin
					if (i_q == n_q) begin
						if (c_end) begin
							clv_q   <= '0;
							xmode_q <= 1'b1;
						end else begin
							clv_q <= clv_q + lv_t'(1);
						end
					end
				end
				ST_C_PL: begin
					i_q   <= i_q + cnt_t'(1);
					ret_q <= ST_C_RD;
				end
				ST_X_RD: begin
					if (i_q == n_q) begin
						k_q <= '0;
					end else begin
						pend_q[cur_e[IDW-1:0]] <= 1'b0;
						i_q <= i_q + cnt_t'(1);
					end
				end
				ST_X_ARM: ret_q <= ST_X_RD;
				ST_SCAN:  k_q <= k_q + scan_t'(1);
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		kind_q   <= e_kind;
		fid_q    <= e_id;
		ok_out_q <= e_ok;
		rem_q    <= e_rem;
		last_q   <= e_last;
		unique case (state_q)
			ST_IDLE: begin
				cmd_q <= cmd_t'(command);
				id_q  <= in_id;
				dly_q <= delay_ticks;
				rep_q <= repeat_req;
				if (cmd_t'(command) == CMD_CANCEL) begin
					ok_q <= hv(in_id) && pend_q[in_id[IDW-1:0]];
				end else begin
					ok_q <= hv(in_id);
				end
				if (t_next[SLOT_BITS-1:0] == sidx_t'(0)) begin
					ds_q <= {lv_t'(1), t_next[2 * SLOT_BITS - 1:SLOT_BITS]};
				end else begin
					ds_q <= {lv_t'(0), t_next[SLOT_BITS-1:0]};
				end
			end
			ST_U1: begin
				u_prev_q <= e_prev;
				u_next_q <= e_next;
				u_slot_q <= e_place;
			end
			ST_SCH_SET: begin
				ed_q  <= dly_q;
				pid_q <= id_q;
			end
			ST_ARM: begin
				pd_q <= a_d;
				pf_q <= tick_q + a_d;
			end
			ST_P0: begin
				ps_q   <= p_slot;
				plv0_q <= (p_lv == lv_t'(0));
			end
			ST_P1: pt_q <= s_tail;
			ST_D1: list_q[0] <= s_head;
			ST_D2: begin
				if (hv(e_next) && n_q < cnt_t'(NUM_TIMERS)) list_q[n_q[IDW-1:0]] <= e_next;
			end
			ST_C_RD: begin
				if (i_q == n_q) begin
					if (c_end) ds_q <= {lv_t'(0), tick_q[SLOT_BITS-1:0]};
					else ds_q <= {clv_q + lv_t'(1), n_idx};
				end
			end
			ST_C_PL: begin
				pid_q <= cur_e;
				ed_q  <= e_delay;
				if (c_df[31]) begin
					pd_q <= 32'd0;
					pf_q <= tick_q;
				end else begin
					pd_q <= c_df;
					pf_q <= e_fire;
				end
			end
			ST_X_RD:  pid_q <= cur_e;
			ST_X_ARM: ed_q <= e_delay;
			default: begin
			end
		endcase
	end

	assign busy         = (state_q != ST_IDLE);
	assign valid        = valid_q;
	assign kind         = kind_q;
	assign fired_id     = fid_q;
	assign ok           = ok_out_q;
	assign remain_ticks = rem_q;
	assign last         = last_q;

endmodule

// ===== rtl/core/htw_chk.sv =====
// Port checker for the hierarchical timer wheel, bound to the top level.
// Depends on htw_pkg for command and result codes.
module htw_chk
	import htw_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  command,
	input logic        valid,
	input logic [1:0]  kind,
	input logic [4:0]  fired_id,
	input logic        ok,
	input logic [8:0]  remain_ticks,
	input logic        last
);

	// A command that yields results keeps the block busy afterward.
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && command != CMD_NOP |=> busy)
		else $error("busy not raised after a command item");

	// The final result of an item is never followed at once by another.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && last |=> !valid)
		else $error("result directly after final result");

	// Acks and tick done close their item.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (kind == KIND_SCHED_ACK || kind == KIND_CANCEL_ACK ||
			kind == KIND_TICK_DONE) |-> last)
		else $error("ack or tick done without last");

	// Expiries are never final and carry no ok; tick done stays in range.
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (kind == KIND_EXPIRY && !last && !ok && remain_ticks == 9'd0) ||
			(kind == KIND_TICK_DONE && remain_ticks <= 9'd256 && fired_id == 5'd0) ||
			kind == KIND_SCHED_ACK || kind == KIND_CANCEL_ACK)
		else $error("result fields out of place");

endmodule

bind hierarchical_timer_wheel htw_chk u_htw_chk (.*);
